>>> rtl/atapio_pkg.sv
`timescale 1ns / 1ps
package atapio_pkg;

    // Configuration register indexes
    localparam logic [2:0] CFG_LBA48       = 3'd0;
    localparam logic [2:0] CFG_SLAVE       = 3'd1;
    localparam logic [2:0] CFG_DRQ_LIMIT   = 3'd2;
    localparam logic [2:0] CFG_FLUSH_LIMIT = 3'd3;
    localparam logic [2:0] CFG_CHUNK       = 3'd4;

    // Configuration reset values
    localparam logic [23:0] DRQ_LIMIT_RST   = 24'd150000;
    localparam logic [23:0] FLUSH_LIMIT_RST = 24'd1500000;
    localparam logic [7:0]  CHUNK_RST       = 8'd128;

    // Input function codes
    localparam logic FUNC_START  = 1'b0;
    localparam logic FUNC_STATUS = 1'b1;

    // Result kinds
    localparam logic [2:0] K_REG    = 3'd0;
    localparam logic [2:0] K_SETTLE = 3'd1;
    localparam logic [2:0] K_POLL   = 3'd2;
    localparam logic [2:0] K_DATA   = 3'd3;
    localparam logic [2:0] K_DONE   = 3'd4;

    // Task-file register offsets
    localparam logic [2:0] TF_SECCNT = 3'd2;
    localparam logic [2:0] TF_LBA_LO = 3'd3;
    localparam logic [2:0] TF_LBA_MD = 3'd4;
    localparam logic [2:0] TF_LBA_HI = 3'd5;
    localparam logic [2:0] TF_DEVSEL = 3'd6;
    localparam logic [2:0] TF_CMD    = 3'd7;

    // Drive select and command bytes
    localparam logic [7:0] SEL_BASE   = 8'hE0;
    localparam logic [7:0] SEL_SLAVE  = 8'h10;
    localparam logic [7:0] CMD_RD28   = 8'h20;
    localparam logic [7:0] CMD_WR28   = 8'h30;
    localparam logic [7:0] CMD_RD48   = 8'h24;
    localparam logic [7:0] CMD_WR48   = 8'h34;
    localparam logic [7:0] CMD_FLSH28 = 8'hE7;
    localparam logic [7:0] CMD_FLSH48 = 8'hEA;

    // Status byte
    localparam logic [7:0] ST_FLOAT = 8'hFF;
    localparam int         ST_BSY   = 7;
    localparam int         ST_DF    = 5;
    localparam int         ST_DRQ   = 3;
    localparam int         ST_ERR   = 0;

    // Tail sequences of a job
    localparam logic [2:0] TAIL_POLL    = 3'd0;
    localparam logic [2:0] TAIL_DONE    = 3'd1;
    localparam logic [2:0] TAIL_FLUSH   = 3'd2;
    localparam logic [2:0] TAIL_CHUNK48 = 3'd3;
    localparam logic [2:0] TAIL_CHUNK28 = 3'd4;

    // Queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // One classified item, expanded by the back end into words
    typedef struct packed {
        logic        data;     // sector transfer word first
        logic        dsettle;  // settle after the transfer word
        logic        dir;      // transfer direction
        logic [2:0]  tail;     // sequence that follows
        logic        ok;       // done status
        logic [7:0]  sel;      // drive select byte
        logic [7:0]  cmd;      // command byte
        logic [7:0]  k;        // sectors in the chunk
        logic [47:0] lba;      // chunk start address
    } t_job;

endpackage

>>> rtl/atapio_ifs.sv
`timescale 1ns / 1ps
interface atapio_in_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [47:0] start_lba;
    logic [15:0] sector_count;
    logic        is_write;
    logic [7:0]  status_byte;

    modport source (output valid, func, start_lba, sector_count, is_write, status_byte,
                    input ready);
    modport sink (input valid, func, start_lba, sector_count, is_write, status_byte,
                  output ready);
endinterface

interface atapio_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [2:0] reg_offset;
    logic [7:0] reg_value;
    logic       data_dir;
    logic       ok;
    logic       last;

    modport source (output valid, kind, reg_offset, reg_value, data_dir, ok, last,
                    input ready);
    modport sink (input valid, kind, reg_offset, reg_value, data_dir, ok, last,
                  output ready);
endinterface

interface atapio_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [23:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/atapio_queue.sv
`timescale 1ns / 1ps
module atapio_queue import atapio_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output t_job o_job,
    output logic o_full,
    output logic o_empty
);

    t_job              r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wr;
    logic [Q_AW-1:0]   r_rd;
    logic [Q_CW-1:0]   r_cnt;

    assign o_full  = (r_cnt == Q_CW'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rd];

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == Q_AW'(Q_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == Q_AW'(Q_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= Q_CW'(Q_DEPTH))
        else $error("queue count beyond depth");

endmodule

>>> rtl/atapio_front.sv
`timescale 1ns / 1ps
module atapio_front import atapio_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    atapio_in_if.sink   i_in,
    atapio_cfg_if.sink  i_cfg,
    input  logic        i_q_full,
    output logic        o_push,
    output t_job        o_job
);

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_DRQ   = 2'd1;
    localparam logic [1:0] PH_FLUSH = 2'd2;

    // Configuration
    logic        r_lba48;
    logic        r_slave;
    logic [23:0] r_drq_lim;
    logic [23:0] r_flush_lim;
    logic [7:0]  r_chunk;

    // Transfer state
    logic [1:0]  r_phase, n_phase;
    logic [47:0] r_lba,   n_lba;
    logic [15:0] r_sl,    n_sl;
    logic [7:0]  r_cl,    n_cl;
    logic [23:0] r_poll,  n_poll;
    logic        r_dir,   n_dir;

    logic        accept;
    logic        push;
    logic        fpoll, want_issue, want_fin, fin_ok;
    logic [47:0] iss_lba;
    logic [15:0] iss_sl;
    logic        iss_dir;
    logic [23:0] limit, pc1;
    logic [47:0] lba_inc;
    logic [15:0] sl_dec;
    logic [7:0]  cl_dec;
    logic [7:0]  cs_eff, k;
    t_job        job;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = !i_q_full;
    assign accept      = i_in.valid && i_in.ready;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lba48     <= 1'b0;
            r_slave     <= 1'b0;
            r_drq_lim   <= DRQ_LIMIT_RST;
            r_flush_lim <= FLUSH_LIMIT_RST;
            r_chunk     <= CHUNK_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_LBA48:       r_lba48     <= i_cfg.data[0];
                CFG_SLAVE:       r_slave     <= i_cfg.data[0];
                CFG_DRQ_LIMIT:   r_drq_lim   <= i_cfg.data;
                CFG_FLUSH_LIMIT: r_flush_lim <= i_cfg.data;
                CFG_CHUNK:       r_chunk     <= i_cfg.data[7:0];
                default: ;
            endcase
        end
    end

    // Classify the item and work out the next state
    always_comb begin
        n_phase    = r_phase;
        n_lba      = r_lba;
        n_sl       = r_sl;
        n_cl       = r_cl;
        n_poll     = r_poll;
        n_dir      = r_dir;
        job        = '0;
        push       = 1'b0;
        fpoll      = 1'b0;
        want_issue = 1'b0;
        want_fin   = 1'b0;
        fin_ok     = 1'b0;
        iss_lba    = r_lba;
        iss_sl     = r_sl;
        iss_dir    = r_dir;
        limit      = (r_phase == PH_DRQ) ? r_drq_lim : r_flush_lim;
        pc1        = r_poll + 24'd1;
        lba_inc    = r_lba + 48'd1;
        sl_dec     = r_sl - 16'd1;
        cl_dec     = r_cl - 8'd1;
        cs_eff     = (r_chunk == 8'd0) ? 8'd1 : r_chunk;
        k          = cs_eff;

        if (i_in.func == FUNC_START) begin
            if (r_phase == PH_IDLE) begin
                push    = 1'b1;
                iss_lba = i_in.start_lba;
                iss_sl  = i_in.sector_count;
                iss_dir = i_in.is_write;
                if (i_in.sector_count == 16'd0) begin
                    want_fin = 1'b1;
                    fin_ok   = 1'b1;
                end else begin
                    want_issue = 1'b1;
                end
            end
        end else if (r_phase != PH_IDLE) begin
            push = 1'b1;
            if (i_in.status_byte == ST_FLOAT) begin
                want_fin = 1'b1;
            end else if (i_in.status_byte[ST_BSY]) begin
                fpoll = 1'b1;
            end else if (i_in.status_byte[ST_ERR] || i_in.status_byte[ST_DF]) begin
                want_fin = 1'b1;
            end else if (r_phase == PH_FLUSH) begin
                // flush finished: next chunk or done
                if (r_sl == 16'd0) begin
                    want_fin = 1'b1;
                    fin_ok   = 1'b1;
                end else begin
                    want_issue = 1'b1;
                end
            end else if (i_in.status_byte[ST_DRQ]) begin
                // one sector granted
                job.data    = 1'b1;
                job.dsettle = r_dir;
                job.dir     = r_dir;
                n_cl        = cl_dec;
                n_sl        = sl_dec;
                n_lba       = lba_inc;
                n_poll      = '0;
                if (cl_dec != 8'd0) begin
                    job.tail = TAIL_POLL;
                end else if (r_dir) begin
                    job.tail = TAIL_FLUSH;
                    job.cmd  = r_lba48 ? CMD_FLSH48 : CMD_FLSH28;
                    n_phase  = PH_FLUSH;
                end else begin
                    iss_lba = lba_inc;
                    iss_sl  = sl_dec;
                    if (sl_dec == 16'd0) begin
                        want_fin = 1'b1;
                        fin_ok   = 1'b1;
                    end else begin
                        want_issue = 1'b1;
                    end
                end
            end else begin
                fpoll = 1'b1;
            end
        end

        // Failed poll: count against the live limit
        if (fpoll) begin
            if (pc1 > limit || pc1 == 24'd0) begin
                want_fin = 1'b1;
            end else begin
                job.tail = TAIL_POLL;
                n_poll   = pc1;
            end
        end

        // New chunk command
        if (want_issue) begin
            if (iss_sl < {8'd0, cs_eff}) begin
                k = iss_sl[7:0];
            end
            job.sel = SEL_BASE | (r_slave ? SEL_SLAVE : 8'h00);
            if (r_lba48) begin
                job.tail = TAIL_CHUNK48;
                job.cmd  = iss_dir ? CMD_WR48 : CMD_RD48;
            end else begin
                job.tail = TAIL_CHUNK28;
                job.cmd  = iss_dir ? CMD_WR28 : CMD_RD28;
                job.sel  = job.sel | {4'h0, iss_lba[27:24]};
            end
            job.k   = k;
            job.lba = iss_lba;
            n_lba   = iss_lba;
            n_sl    = iss_sl;
            n_dir   = iss_dir;
            n_cl    = k;
            n_poll  = '0;
            n_phase = PH_DRQ;
            // 28-bit address out of reach
            if (!r_lba48 && iss_lba[47:28] != 20'd0) begin
                want_fin = 1'b1;
            end
        end

        // Done: back to idle with everything cleared
        if (want_fin) begin
            job.tail = TAIL_DONE;
            job.ok   = fin_ok;
            n_phase  = PH_IDLE;
            n_lba    = '0;
            n_sl     = '0;
            n_cl     = '0;
            n_poll   = '0;
            n_dir    = 1'b0;
        end
    end

    assign o_push = accept && push;
    assign o_job  = job;

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_lba   <= '0;
            r_sl    <= '0;
            r_cl    <= '0;
            r_poll  <= '0;
            r_dir   <= 1'b0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_lba   <= n_lba;
            r_sl    <= n_sl;
            r_cl    <= n_cl;
            r_poll  <= n_poll;
            r_dir   <= n_dir;
        end
    end

    a_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_IDLE |-> (r_sl == 16'd0 && r_cl == 8'd0 && r_poll == 24'd0))
        else $error("idle with live counters");

    a_drq_chunk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_DRQ |-> r_cl != 8'd0)
        else $error("waiting for DRQ with empty chunk");

    a_flush_chunk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_FLUSH |-> (r_cl == 8'd0 && r_dir))
        else $error("flush outside a finished write chunk");

endmodule

>>> rtl/atapio_back.sv
`timescale 1ns / 1ps
module atapio_back import atapio_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_job          i_job,
    input  logic          i_empty,
    output logic          o_pop,
    atapio_out_if.source  o_out
);

    logic [3:0] r_step;
    logic [4:0] pos;
    logic [4:0] t;
    logic       last;
    logic       accepted;

    // Word sequence: transfer and settle where the job has them, then the tail
    always_comb begin
        if (!i_job.data) begin
            pos = {1'b0, r_step} + 5'd2;
        end else if (r_step == 4'd0) begin
            pos = 5'd0;
        end else if (i_job.dsettle) begin
            pos = {1'b0, r_step};
        end else begin
            pos = {1'b0, r_step} + 5'd1;
        end
        t = pos - 5'd2;
    end

    // Word generation
    always_comb begin
        o_out.kind       = K_SETTLE;
        o_out.reg_offset = 3'd0;
        o_out.reg_value  = 8'd0;
        o_out.data_dir   = 1'b0;
        o_out.ok         = 1'b0;
        last             = 1'b0;
        if (pos == 5'd0) begin
            o_out.kind     = K_DATA;
            o_out.data_dir = i_job.dir;
        end else if (pos == 5'd1) begin
            o_out.kind = K_SETTLE;
        end else begin
            unique case (i_job.tail)
                TAIL_POLL: begin
                    o_out.kind = K_POLL;
                    last       = 1'b1;
                end
                TAIL_DONE: begin
                    o_out.kind = K_DONE;
                    o_out.ok   = i_job.ok;
                    last       = 1'b1;
                end
                TAIL_FLUSH: begin
                    case (t)
                        5'd0: begin
                            o_out.kind       = K_REG;
                            o_out.reg_offset = TF_CMD;
                            o_out.reg_value  = i_job.cmd;
                        end
                        5'd1: o_out.kind = K_SETTLE;
                        default: begin
                            o_out.kind = K_POLL;
                            last       = 1'b1;
                        end
                    endcase
                end
                TAIL_CHUNK48: begin
                    o_out.kind = K_REG;
                    case (t)
                        5'd0: begin
                            o_out.reg_offset = TF_DEVSEL;
                            o_out.reg_value  = i_job.sel;
                        end
                        5'd1: o_out.kind = K_SETTLE;
                        5'd2: o_out.reg_offset = TF_SECCNT;  // count high byte is zero
                        5'd3: begin
                            o_out.reg_offset = TF_LBA_LO;
                            o_out.reg_value  = i_job.lba[31:24];
                        end
                        5'd4: begin
                            o_out.reg_offset = TF_LBA_MD;
                            o_out.reg_value  = i_job.lba[39:32];
                        end
                        5'd5: begin
                            o_out.reg_offset = TF_LBA_HI;
                            o_out.reg_value  = i_job.lba[47:40];
                        end
                        5'd6: begin
                            o_out.reg_offset = TF_SECCNT;
                            o_out.reg_value  = i_job.k;
                        end
                        5'd7: begin
                            o_out.reg_offset = TF_LBA_LO;
                            o_out.reg_value  = i_job.lba[7:0];
                        end
                        5'd8: begin
                            o_out.reg_offset = TF_LBA_MD;
                            o_out.reg_value  = i_job.lba[15:8];
                        end
                        5'd9: begin
                            o_out.reg_offset = TF_LBA_HI;
                            o_out.reg_value  = i_job.lba[23:16];
                        end
                        5'd10: begin
                            o_out.reg_offset = TF_CMD;
                            o_out.reg_value  = i_job.cmd;
                        end
                        5'd11: o_out.kind = K_SETTLE;
                        default: begin
                            o_out.kind = K_POLL;
                            last       = 1'b1;
                        end
                    endcase
                end
                TAIL_CHUNK28: begin
                    o_out.kind = K_REG;
                    case (t)
                        5'd0: begin
                            o_out.reg_offset = TF_DEVSEL;
                            o_out.reg_value  = i_job.sel;
                        end
                        5'd1: o_out.kind = K_SETTLE;
                        5'd2: begin
                            o_out.reg_offset = TF_SECCNT;
                            o_out.reg_value  = i_job.k;
                        end
                        5'd3: begin
                            o_out.reg_offset = TF_LBA_LO;
                            o_out.reg_value  = i_job.lba[7:0];
                        end
                        5'd4: begin
                            o_out.reg_offset = TF_LBA_MD;
                            o_out.reg_value  = i_job.lba[15:8];
                        end
                        5'd5: begin
                            o_out.reg_offset = TF_LBA_HI;
                            o_out.reg_value  = i_job.lba[23:16];
                        end
                        5'd6: begin
                            o_out.reg_offset = TF_CMD;
                            o_out.reg_value  = i_job.cmd;
                        end
                        5'd7: o_out.kind = K_SETTLE;
                        default: begin
                            o_out.kind = K_POLL;
                            last       = 1'b1;
                        end
                    endcase
                end
                default: begin
                    o_out.kind = K_DONE;
                    last       = 1'b1;
                end
            endcase
        end
    end

    assign o_out.valid = !i_empty;
    assign o_out.last  = last;
    assign accepted    = o_out.valid && o_out.ready;
    assign o_pop       = accepted && last;

    // Word counter within the current job
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else if (accepted) begin
            r_step <= last ? 4'd0 : r_step + 4'd1;
        end
    end

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |=> r_step == $past(r_step))
        else $error("word position moved while stalled");

    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_empty |-> pos <= 5'd14)
        else $error("word position past longest sequence");

endmodule

>>> rtl/ata_pio_transfer_sequencer_core.sv
`timescale 1ns / 1ps
// An accepted item is registered in the job queue; its first word is offered from the head.
// Throughput: one item accepted per cycle while the 2-entry job queue has room; each item
// expands into 0 to 14 words, sent one per cycle unless stalled; output sets the pace.
// Reset (i_rst_n low at a clock edge) idles the sequencer, empties the queue and
// loads the configuration defaults: 28-bit mode, master, 150000/1500000 polls, 128 sectors.
module ata_pio_transfer_sequencer_core import atapio_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    atapio_in_if.sink     i_in,
    atapio_cfg_if.sink    i_cfg,
    atapio_out_if.source  o_out
);

    logic q_full;
    logic q_empty;
    logic push;
    logic pop;
    t_job job_in;
    t_job job_out;

    // Front: accepts and classifies items
    atapio_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_cfg    (i_cfg),
        .i_q_full (q_full),
        .o_push   (push),
        .o_job    (job_in)
    );

    // Job queue
    atapio_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .i_pop   (pop),
        .o_job   (job_out),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // Back: expands jobs into words
    atapio_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (job_out),
        .i_empty (q_empty),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

>>> dv/ata_pio_transfer_sequencer_core_tb.sv
`timescale 1ns / 1ps
package atapio_tb_pkg;
    import atapio_pkg::*;

    localparam logic [47:0] LBA28_MAX = 48'h0FFF_FFFF;

    typedef enum logic [1:0] {SEQ_IDLE, SEQ_WAIT_DRQ, SEQ_WAIT_FLUSH} seq_phase_e;

    // One input word: a start request or a status sample
    typedef struct packed {
        logic        func;
        logic [47:0] start_lba;
        logic [15:0] count;
        logic        is_write;
        logic [7:0]  status;
    } pio_req_t;

    // One output word
    typedef struct packed {
        logic [2:0] kind;
        logic [2:0] off;
        logic [7:0] val;
        logic       dir;
        logic       ok;
        logic       last;
    } pio_word_t;

    // Sequencer predictor plus in-order store of the words it expects
    class pio_scoreboard;
        // live configuration
        logic        lba48;
        logic        slave;
        logic [23:0] drq_limit;
        logic [23:0] flush_limit;
        logic [7:0]  chunk_max;
        // transfer state
        seq_phase_e  ph;
        logic [47:0] lba;
        logic [15:0] left;
        logic [7:0]  chunk_left;
        logic [23:0] polls;
        logic        wr;

        pio_word_t expected[$];
        pio_word_t step[$];
        int mismatches, words_checked, items_seen, items_used;
        int transfers_ok, transfers_failed, sectors_moved;

        function new();
            lba48 = 1'b0;
            slave = 1'b0;
            drq_limit = DRQ_LIMIT_RST;
            flush_limit = FLUSH_LIMIT_RST;
            chunk_max = CHUNK_RST;
            clear_transfer();
            mismatches = 0;
            words_checked = 0;
            items_seen = 0;
            items_used = 0;
            transfers_ok = 0;
            transfers_failed = 0;
            sectors_moved = 0;
        endfunction

        function void clear_transfer();
            ph = SEQ_IDLE;
            lba = '0;
            left = '0;
            chunk_left = '0;
            polls = '0;
            wr = 1'b0;
        endfunction

        function bit busy();
            return ph != SEQ_IDLE;
        endfunction

        function int pending();
            return expected.size();
        endfunction

        function void config_write(logic [2:0] idx, logic [23:0] v);
            case (idx)
                CFG_LBA48:       lba48 = v[0];
                CFG_SLAVE:       slave = v[0];
                CFG_DRQ_LIMIT:   drq_limit = v;
                CFG_FLUSH_LIMIT: flush_limit = v;
                CFG_CHUNK:       chunk_max = v[7:0];
                default: ;
            endcase
        endfunction

        function void push_word(logic [2:0] kind, logic [2:0] off, logic [7:0] val,
                                logic dir, logic okv);
            pio_word_t w;
            w.kind = kind;
            w.off = off;
            w.val = val;
            w.dir = dir;
            w.ok = okv;
            w.last = 1'b0;
            if (step.size() < 16) step.push_back(w);
        endfunction

        function void put_reg(logic [2:0] off, logic [7:0] val);
            push_word(K_REG, 3'd0 | off, val, 1'b0, 1'b0);
        endfunction

        function void end_transfer(logic okv);
            push_word(K_DONE, 3'd0, 8'd0, 1'b0, okv);
            if (okv) transfers_ok++;
            else transfers_failed++;
            clear_transfer();
        endfunction

        // Task-file writes for the next chunk, then ask for status
        function void open_chunk();
            logic [7:0] k;
            logic [7:0] sel;
            k = (chunk_max == 8'd0) ? 8'd1 : chunk_max;
            if (left < {8'd0, k}) k = left[7:0];
            sel = SEL_BASE | (slave ? SEL_SLAVE : 8'h00);
            if (lba48) begin
                put_reg(TF_DEVSEL, sel);
                push_word(K_SETTLE, 3'd0, 8'd0, 1'b0, 1'b0);
                put_reg(TF_SECCNT, 8'h00);   // count high byte, chunk never exceeds 255
                put_reg(TF_LBA_LO, lba[31:24]);
                put_reg(TF_LBA_MD, lba[39:32]);
                put_reg(TF_LBA_HI, lba[47:40]);
                put_reg(TF_SECCNT, k);
                put_reg(TF_LBA_LO, lba[7:0]);
                put_reg(TF_LBA_MD, lba[15:8]);
                put_reg(TF_LBA_HI, lba[23:16]);
                put_reg(TF_CMD, wr ? CMD_WR48 : CMD_RD48);
            end else begin
                if (lba > LBA28_MAX) begin
                    end_transfer(1'b0);
                    return;
                end
                put_reg(TF_DEVSEL, sel | {4'h0, lba[27:24]});
                push_word(K_SETTLE, 3'd0, 8'd0, 1'b0, 1'b0);
                put_reg(TF_SECCNT, k);
                put_reg(TF_LBA_LO, lba[7:0]);
                put_reg(TF_LBA_MD, lba[15:8]);
                put_reg(TF_LBA_HI, lba[23:16]);
                put_reg(TF_CMD, wr ? CMD_WR28 : CMD_RD28);
            end
            push_word(K_SETTLE, 3'd0, 8'd0, 1'b0, 1'b0);
            push_word(K_POLL, 3'd0, 8'd0, 1'b0, 1'b0);
            chunk_left = k;
            polls = '0;
            ph = SEQ_WAIT_DRQ;
        endfunction

        function void missed_poll(logic [23:0] lim);
            polls = polls + 24'd1;
            if (polls > lim || polls == 24'd0) end_transfer(1'b0);
            else push_word(K_POLL, 3'd0, 8'd0, 1'b0, 1'b0);
        endfunction

        function void close_chunk();
            if (left == 16'd0) end_transfer(1'b1);
            else open_chunk();
        endfunction

        // Work out the words caused by one accepted input word
        function void note_item(pio_req_t q);
            logic [23:0] lim;
            step.delete();
            items_seen++;
            if (q.func == FUNC_START) begin
                if (ph == SEQ_IDLE) begin
                    lba = q.start_lba;
                    left = q.count;
                    wr = q.is_write;
                    polls = '0;
                    chunk_left = '0;
                    if (left == 16'd0) end_transfer(1'b1);
                    else open_chunk();
                end
            end else if (ph != SEQ_IDLE) begin
                lim = (ph == SEQ_WAIT_DRQ) ? drq_limit : flush_limit;
                if (q.status == ST_FLOAT) begin
                    end_transfer(1'b0);
                end else if (q.status[ST_BSY]) begin
                    missed_poll(lim);
                end else if (q.status[ST_ERR] || q.status[ST_DF]) begin
                    end_transfer(1'b0);
                end else if (ph == SEQ_WAIT_FLUSH) begin
                    close_chunk();
                end else if (q.status[ST_DRQ]) begin
                    push_word(K_DATA, 3'd0, 8'd0, wr, 1'b0);
                    if (wr) push_word(K_SETTLE, 3'd0, 8'd0, 1'b0, 1'b0);
                    chunk_left = chunk_left - 8'd1;
                    left = left - 16'd1;
                    lba = lba + 48'd1;
                    polls = '0;
                    sectors_moved++;
                    if (chunk_left != 8'd0) begin
                        push_word(K_POLL, 3'd0, 8'd0, 1'b0, 1'b0);
                    end else if (wr) begin
                        // write chunk ends with a cache flush
                        put_reg(TF_CMD, lba48 ? CMD_FLSH48 : CMD_FLSH28);
                        push_word(K_SETTLE, 3'd0, 8'd0, 1'b0, 1'b0);
                        push_word(K_POLL, 3'd0, 8'd0, 1'b0, 1'b0);
                        ph = SEQ_WAIT_FLUSH;
                    end else begin
                        close_chunk();
                    end
                end else begin
                    missed_poll(lim);
                end
            end
            if (step.size() > 0) begin
                step[step.size() - 1].last = 1'b1;
                items_used++;
            end
            foreach (step[i]) expected.push_back(step[i]);
        endfunction

        function string show(pio_word_t w);
            return $sformatf("kind=%0d off=%0d val=%02h dir=%0d ok=%0d last=%0d",
                             w.kind, w.off, w.val, w.dir, w.ok, w.last);
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= 10) $display("ERROR: %s", msg);
        endfunction

        function void check_word(pio_word_t got);
            pio_word_t want;
            words_checked++;
            if (expected.size() == 0) begin
                flag($sformatf("word %0d not expected: %s", words_checked, show(got)));
                return;
            end
            want = expected.pop_front();
            if (got.kind != want.kind || got.off != want.off || got.val != want.val ||
                got.dir != want.dir || got.ok != want.ok || got.last != want.last)
                flag($sformatf("word %0d mismatch: expected %s, actual %s",
                               words_checked, show(want), show(got)));
        endfunction
    endclass
endpackage

module ata_pio_transfer_sequencer_core_tb;
    import atapio_pkg::*;
    import atapio_tb_pkg::*;

    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_ITEMS  = 62;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    atapio_in_if  in_if();
    atapio_out_if out_if();
    atapio_cfg_if cfg_if();

    ata_pio_transfer_sequencer_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .i_cfg   (cfg_if),
        .o_out   (out_if)
    );

    pio_scoreboard sb = new();
    bit calm = 1'b0;      // no idling on either side
    int hold_asks = 0;    // bumped to make the receiver hold off

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Receiver: random stalls, plus long hold-offs on request
    initial begin
        int hold_left;
        int holds_seen;
        hold_left = 0;
        holds_seen = 0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_asks != holds_seen) begin
                holds_seen = hold_asks;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= calm || ($urandom_range(99) >= 28);
            end
        end
    end

    // Output monitor
    always @(posedge i_clk) begin
        pio_word_t got;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got.kind = out_if.kind;
            got.off = out_if.reg_offset;
            got.val = out_if.reg_value;
            got.dir = out_if.data_dir;
            got.ok = out_if.ok;
            got.last = out_if.last;
            sb.check_word(got);
        end
    end

    function automatic pio_req_t mk(logic func, logic [47:0] lba, logic [15:0] cnt,
                                    logic wr, logic [7:0] st);
        pio_req_t q;
        q.func = func;
        q.start_lba = lba;
        q.count = cnt;
        q.is_write = wr;
        q.status = st;
        return q;
    endfunction

    function automatic logic [47:0] pick_lba();
        logic [63:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(9))
            0, 1: return r[47:0];
            2: return 48'hFFFF_FFFF_FFFF - 48'($urandom_range(2));
            3: return LBA28_MAX - 48'($urandom_range(2));
            4: return LBA28_MAX + 48'($urandom_range(1, 2));
            default: return 48'(r[27:0] >> $urandom_range(27));
        endcase
    endfunction

    function automatic logic [15:0] pick_count();
        case ($urandom_range(19))
            0: return 16'd0;
            1: return 16'($urandom);
            2: return 16'hFFFF;
            default: return 16'($urandom_range(1, 6));
        endcase
    endfunction

    // Mostly clean DRQ grants, with busy, idle-no-DRQ, error and floating samples
    function automatic logic [7:0] pick_status();
        logic [7:0] r;
        int v;
        r = 8'($urandom);
        v = $urandom_range(99);
        if (v < 70) return (r & 8'h56) | (8'h01 << ST_DRQ);
        if (v < 82) return ((r | (8'h01 << ST_BSY)) == ST_FLOAT) ? 8'hFE : (r | 8'h80);
        if (v < 88) return r & 8'h56;
        if (v < 94) return (r & 8'h7F) | ($urandom_range(1) ? (8'h01 << ST_ERR)
                                                             : (8'h01 << ST_DF));
        if (v < 96) return ST_FLOAT;
        return r;
    endfunction

    // Next word, shaped by where the predicted transfer stands
    function automatic pio_req_t next_req();
        pio_req_t q;
        logic [63:0] r;
        r = {$urandom, $urandom};
        q = mk(FUNC_STATUS, r[47:0], r[63:48], 1'($urandom_range(1)), 8'($urandom));
        if (!sb.busy()) begin
            if ($urandom_range(9) != 0) begin
                q.func = FUNC_START;
                q.start_lba = pick_lba();
                q.count = pick_count();
            end
        end else if ($urandom_range(99) < 6) begin
            q.func = FUNC_START;
        end else begin
            q.status = pick_status();
        end
        return q;
    endfunction

    task automatic send(input pio_req_t q);
        in_if.func <= q.func;
        in_if.start_lba <= q.start_lba;
        in_if.sector_count <= q.count;
        in_if.is_write <= q.is_write;
        in_if.status_byte <= q.status;
        in_if.valid <= 1'b1;
        do @(posedge i_clk); while (!in_if.ready);
        sb.note_item(q);
    endtask

    // Random source gaps, then one word
    task automatic issue(input pio_req_t q);
        while (!calm && $urandom_range(99) < 28) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        send(q);
    endtask

    // Stop offering and wait for every expected word
    task automatic drain();
        in_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [23:0] v);
        cfg_if.index <= idx;
        cfg_if.data <= v;
        cfg_if.valid <= 1'b1;
        do @(posedge i_clk); while (!cfg_if.ready);
        sb.config_write(idx, v);
    endtask

    task automatic set_config(input logic l48, input logic sl, input logic [23:0] drq,
                              input logic [23:0] fl, input logic [7:0] ch);
        write_reg(CFG_LBA48, {23'd0, l48});
        write_reg(CFG_SLAVE, {23'd0, sl});
        write_reg(CFG_DRQ_LIMIT, drq);
        write_reg(CFG_FLUSH_LIMIT, fl);
        write_reg(CFG_CHUNK, {16'd0, ch});
        cfg_if.valid <= 1'b0;
    endtask

    // Random traffic; ends with any open transfer aborted so config can change
    task automatic run_phase(input int n, input bit hold_mid, input bit drain_mid);
        int target;
        target = sb.items_used + n;
        while (sb.items_used < target) begin
            if (sb.items_used == target - n / 2) begin
                if (hold_mid) begin
                    hold_asks++;
                    hold_mid = 1'b0;
                end
                if (drain_mid) begin
                    drain();
                    drain_mid = 1'b0;
                end
            end
            issue(next_req());
        end
        if (sb.busy()) issue(mk(FUNC_STATUS, 48'd0, 16'd0, 1'b0, ST_FLOAT));
        drain();
    endtask

    // Watchdog
    initial begin
        #3_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        int errors;
        in_if.valid <= 1'b0;
        in_if.func <= FUNC_START;
        in_if.start_lba <= '0;
        in_if.sector_count <= '0;
        in_if.is_write <= 1'b0;
        in_if.status_byte <= '0;
        cfg_if.valid <= 1'b0;
        cfg_if.index <= CFG_LBA48;
        cfg_if.data <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed, reset config: 28-bit, master, chunk 128
        issue(mk(FUNC_STATUS, 48'd0, 16'd0, 1'b0, 8'h08));          // status while idle
        issue(mk(FUNC_START, 48'h123, 16'd0, 1'b0, 8'h00));         // zero-length request
        issue(mk(FUNC_START, 48'h0ABCDEF, 16'd2, 1'b0, 8'h00));
        issue(mk(FUNC_STATUS, 48'd0, 16'd0, 1'b0, 8'h08));
        issue(mk(FUNC_START, 48'h5, 16'd3, 1'b1, 8'h00));           // start while busy
        issue(mk(FUNC_STATUS, 48'd0, 16'd0, 1'b0, 8'h80));          // busy
        issue(mk(FUNC_STATUS, 48'd0, 16'd0, 1'b0, 8'h00));          // ready but no DRQ
        issue(mk(FUNC_STATUS, 48'd0, 16'd0, 1'b0, 8'h08));
        issue(mk(FUNC_START, LBA28_MAX + 48'd1, 16'd1, 1'b0, 8'h00)); // beyond 28-bit reach
        issue(mk(FUNC_START, LBA28_MAX, 16'd1, 1'b1, 8'h00));       // last 28-bit sector, write
        issue(mk(FUNC_STATUS, 48'd0, 16'd0, 1'b0, 8'h08));
        issue(mk(FUNC_STATUS, 48'd0, 16'd0, 1'b0, 8'h80));
        issue(mk(FUNC_STATUS, 48'd0, 16'd0, 1'b0, 8'h40));          // flush done
        issue(mk(FUNC_START, 48'd0, 16'd1, 1'b0, 8'h00));
        issue(mk(FUNC_STATUS, 48'd0, 16'd0, 1'b0, ST_FLOAT));       // floating bus
        issue(mk(FUNC_START, 48'd7, 16'd1, 1'b1, 8'h00));
        issue(mk(FUNC_STATUS, 48'd0, 16'd0, 1'b0, 8'h01));          // ERR
        issue(mk(FUNC_START, 48'd8, 16'd1, 1'b0, 8'h00));
        issue(mk(FUNC_STATUS, 48'd0, 16'd0, 1'b0, 8'h28));          // DF with DRQ
        drain();

        // 48-bit slave, zero chunk size and zero DRQ limit, address wrap
        set_config(1'b1, 1'b1, 24'd0, 24'd1, 8'd0);
        issue(mk(FUNC_START, 48'hFFFF_FFFF_FFFF, 16'd2, 1'b1, 8'h00));
        issue(mk(FUNC_STATUS, 48'd0, 16'd0, 1'b0, 8'h08));
        issue(mk(FUNC_STATUS, 48'd0, 16'd0, 1'b0, 8'h80));          // flush poll within limit
        issue(mk(FUNC_STATUS, 48'd0, 16'd0, 1'b0, 8'h00));          // flush done, next chunk at 0
        issue(mk(FUNC_STATUS, 48'd0, 16'd0, 1'b0, 8'h80));          // immediate DRQ timeout
        drain();

        // Random phases over several settings
        set_config(1'b0, 1'b0, 24'd3, 24'd2, 8'd2);
        run_phase(PHASE_ITEMS, 1'b0, 1'b1);
        calm = 1'b1;
        set_config(1'b1, 1'b1, 24'd1, 24'd1, 8'd1);
        run_phase(PHASE_ITEMS, 1'b0, 1'b0);
        calm = 1'b0;
        set_config(1'b1, 1'b0, 24'hFFFFFF, 24'hFFFFFF, 8'd255);
        run_phase(PHASE_ITEMS, 1'b1, 1'b0);
        set_config(1'b0, 1'b1, 24'd2, 24'd3, 8'd3);
        run_phase(PHASE_ITEMS, 1'b0, 1'b0);
        set_config(1'($urandom_range(1)), 1'($urandom_range(1)), 24'($urandom_range(1, 4)),
                   24'($urandom_range(1, 4)), 8'($urandom_range(1, 5)));
        run_phase(PHASE_ITEMS, 1'b0, 1'b0);
        set_config(1'b1, 1'b1, 24'd4, 24'd2, 8'd4);
        run_phase(PHASE_ITEMS, 1'b1, 1'b1);

        errors = sb.mismatches + sb.pending();
        $display("Run covered %0d input words (%0d acted on) and %0d output words checked.",
                 sb.items_seen, sb.items_used, sb.words_checked);
        $display("Transfers: %0d completed, %0d failed or timed out, %0d sectors moved.",
                 sb.transfers_ok, sb.transfers_failed, sb.sectors_moved);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches, %0d words still expected", sb.mismatches, sb.pending());
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
